>>> rtl/core/lesf_pkg.sv
// shared types and constants for the largest empty square finder
package lesf_pkg;

    localparam int CHAR_W = 8;
    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHAR_W-1:0] OBSTACLE_RST   = 8'd111;
    localparam int                ROW_LENGTH_RST = 1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_CHAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH    = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic              last_cell;
    } t_cell_word;

    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] square_size;
        logic [POS_W-1:0]  corner_row;
        logic [POS_W-1:0]  corner_col;
        logic              overflow;
    } t_result_word;

    // per-cell control handed from the scan stage to the evaluate stage
    typedef struct packed {
        logic empty;
        logic border;
        logic over;
        logic last;
    } t_cell_flags;

endpackage

>>> rtl/core/lesf_if.sv
// stream interfaces for grid cell words and result words
interface lesf_cell_if import lesf_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cell_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lesf_result_if import lesf_pkg::*; ();
    logic         valid;
    logic         ready;
    t_result_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/largest_empty_square_finder.sv
// largest empty square finder: one grid cell word per cycle, one result per grid
// throughput: one cell word per cycle unless a last word waits on a stalled result,
// set by the single read and write port pair of the line buffer; the result word is
// registered as the last word leaves the evaluate stage; synchronous active-low reset
// clears counters, running best, pipeline and output valid, restores the registers to
// defaults; uncleared line buffer data is only used at columns this grid has written
module largest_empty_square_finder import lesf_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data,
    lesf_cell_if.sink            i_cell,
    lesf_result_if.source        o_result
);

    // column index, saturating row count, row index and cell value widths
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int RIW = $clog2(MAX_ROWS);
    localparam int VW  = $clog2(MAX_COLS + 1);

    logic          acc;
    logic          s1_ready;
    logic [CW-1:0] col;
    logic [RIW-1:0] row;
    t_cell_flags   flags;
    logic [VW-1:0] rd_data;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic [VW-1:0] wr_data;

    // a word enters whenever the evaluate stage is empty or moving on
    assign i_cell.ready = s1_ready;
    assign acc          = i_cell.valid && s1_ready;

    // scan stage: raster position and cell classification at acceptance
    lesf_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CW       (CW),
        .RW       (RW),
        .RIW      (RIW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_cell     (i_cell.data),
        .o_col      (col),
        .o_row      (row),
        .o_flags    (flags)
    );

    // previous row values, read at acceptance and written back as the word leaves the evaluate stage
    lesf_line_buf #(
        .DEPTH (MAX_COLS),
        .AW    (CW),
        .DW    (VW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (col),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // evaluate stage: min of left, up and diagonal plus one, best tracking,
    // forwarding when consecutive words hit the same column (row length one)
    lesf_eval #(
        .CW  (CW),
        .RIW (RIW),
        .VW  (VW)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_col       (col),
        .i_row       (row),
        .i_flags     (flags),
        .o_ready     (s1_ready),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_out_data  (o_result.data)
    );

endmodule

>>> rtl/core/lesf_line_buf.sv
// previous-row line buffer, one write port and one registered read port
module lesf_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/lesf_scan.sv
// configuration registers and raster position counters
module lesf_scan import lesf_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    parameter int CW       = 10,
    parameter int RW       = 11,
    parameter int RIW      = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data,
    input  logic                 i_acc,
    input  t_cell_word           i_cell,
    output logic [CW-1:0]        o_col,
    output logic [RIW-1:0]       o_row,
    output t_cell_flags          o_flags
);

    localparam int LEN_M1_RST = (ROW_LENGTH_RST > MAX_COLS) ? MAX_COLS - 1
                                                             : ROW_LENGTH_RST - 1;

    logic [CHAR_W-1:0] r_obstacle;
    logic [CW-1:0]     r_len_m1;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     cfg_len_m1;
    logic              over;

    // clamp the row length into 1..MAX_COLS and keep it minus one
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_len_m1 = '0;
        end else if (32'(i_cfg_data) > 32'(MAX_COLS)) begin
            cfg_len_m1 = CW'(MAX_COLS - 1);
        end else begin
            cfg_len_m1 = CW'(i_cfg_data - LEN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle <= OBSTACLE_RST;
            r_len_m1   <= CW'(LEN_M1_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OBSTACLE_CHAR: r_obstacle <= i_cfg_data[CHAR_W-1:0];
                REG_ROW_LENGTH:    r_len_m1   <= cfg_len_m1;
                default: ;
            endcase
        end
    end

    assign over = (r_row >= RW'(MAX_ROWS));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cell.last_cell) begin
            n_col = '0;
            n_row = '0;
        end else if (r_col >= r_len_m1) begin
            n_col = '0;
            if (!over) begin
                n_row = r_row + RW'(1);
            end
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col          = r_col;
    assign o_row          = RIW'(r_row);
    assign o_flags.empty  = (i_cell.cell_char != r_obstacle);
    assign o_flags.border = (r_row == '0) || (r_col == '0);
    assign o_flags.over   = over;
    assign o_flags.last   = i_cell.last_cell;

endmodule

>>> rtl/core/lesf_eval.sv
// cell value update, line buffer write-back, best square tracking, result register
module lesf_eval import lesf_pkg::*; #(
    parameter int CW  = 10,
    parameter int RIW = 10,
    parameter int VW  = 11
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  logic [CW-1:0]  i_col,
    input  logic [RIW-1:0] i_row,
    input  t_cell_flags    i_flags,
    output logic           o_ready,
    input  logic [VW-1:0]  i_rd_data,
    output logic           o_wr_en,
    output logic [CW-1:0]  o_wr_addr,
    output logic [VW-1:0]  o_wr_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output t_result_word   o_out_data
);

    logic           r_s1_valid;
    logic [CW-1:0]  r_s1_col;
    logic [RIW-1:0] r_s1_row;
    t_cell_flags    r_s1_flags;
    logic           r_fwd_hit;
    logic [VW-1:0]  r_fwd_val;
    logic [VW-1:0]  r_left, r_diag;
    logic [VW-1:0]  r_best_size;
    logic [RIW-1:0] r_best_row;
    logic [CW-1:0]  r_best_col;
    logic           r_out_valid;
    t_result_word   r_out_data;

    logic [VW-1:0]  up, min_lu, min3, val;
    logic           out_free, s1_go, eval_en, better;
    logic [VW-1:0]  n_best_size;
    logic [RIW-1:0] n_best_row;
    logic [CW-1:0]  n_best_col;

    // up value: forwarded when the previous word wrote the same column
    assign up     = r_fwd_hit ? r_fwd_val : i_rd_data;
    assign min_lu = (r_left < up) ? r_left : up;
    assign min3   = (r_diag < min_lu) ? r_diag : min_lu;

    always_comb begin
        if (!r_s1_flags.empty) begin
            val = '0;
        end else if (r_s1_flags.border) begin
            val = VW'(1);
        end else begin
            val = min3 + VW'(1);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign s1_go    = r_s1_valid && (!r_s1_flags.last || out_free);
    assign o_ready  = !r_s1_valid || s1_go;
    assign eval_en  = !r_s1_flags.over;
    assign better   = eval_en && (val > r_best_size);

    assign n_best_size = better ? val : r_best_size;
    assign n_best_row  = better ? r_s1_row : r_best_row;
    assign n_best_col  = better ? r_s1_col : r_best_col;

    assign o_wr_en   = s1_go && eval_en;
    assign o_wr_addr = r_s1_col;
    assign o_wr_data = val;

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_col   <= i_col;
            r_s1_row   <= i_row;
            r_s1_flags <= i_flags;
            r_fwd_hit  <= o_wr_en && (r_s1_col == i_col);
            r_fwd_val  <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (s1_go) begin
            if (r_s1_flags.last) begin
                r_left      <= '0;
                r_diag      <= '0;
                r_best_size <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else if (eval_en) begin
                r_left      <= val;
                r_diag      <= up;
                r_best_size <= n_best_size;
                r_best_row  <= n_best_row;
                r_best_col  <= n_best_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_flags.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_flags.last) begin
            r_out_data.found       <= (n_best_size != '0);
            r_out_data.square_size <= SIZE_W'(n_best_size);
            r_out_data.corner_row  <= POS_W'(n_best_row);
            r_out_data.corner_col  <= POS_W'(n_best_col);
            r_out_data.overflow    <= r_s1_flags.over;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/core/lesf_checker.sv
// port-level checks for the largest empty square finder and their bind
module lesf_checker import lesf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic         i_in_last,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  t_result_word i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    a_out_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result word without a last cell two cycles earlier");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.found |->
            i_out_data.square_size == '0 && i_out_data.corner_row == '0 &&
            i_out_data.corner_col == '0)
        else $error("empty result carries a square");

    a_found_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.found |-> i_out_data.square_size != '0)
        else $error("found square has zero size");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cell.valid),
    .i_in_ready  (i_cell.ready),
    .i_in_last   (i_cell.data.last_cell),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
